// ===== rtl/owvcs_pkg.sv =====
// Package for the one-wire voice command sender.
// Holds the beat types, register map, reset values and sequencer phases.
// No dependencies.
package owvcs_pkg;

  localparam int TIMER_WIDTH_DEF = 16;
  localparam int WORD_BYTES_DEF  = 4;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int TICK_W     = 16;

  localparam logic [TICK_W-1:0] SYNC_HIGH_RST = 16'd8000;
  localparam logic [TICK_W-1:0] SYNC_LOW_RST  = 16'd1000;
  localparam logic [TICK_W-1:0] LONG_RST      = 16'd1500;
  localparam logic [TICK_W-1:0] SHORT_RST     = 16'd500;
  localparam logic [TICK_W-1:0] POWER_UP_RST  = 16'd50000;
  localparam logic [TICK_W-1:0] SETTLE_RST    = 16'd5000;
  localparam logic [7:0]        VOLUME_RST    = 8'h00;

  typedef enum logic [2:0] {
    REG_SYNC_HIGH = 3'd0,
    REG_SYNC_LOW  = 3'd1,
    REG_LONG      = 3'd2,
    REG_SHORT     = 3'd3,
    REG_POWER_UP  = 3'd4,
    REG_SETTLE    = 3'd5,
    REG_VOLUME    = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_POWERUP   = 4'd1,
    PH_BUSY_PRE  = 4'd2,
    PH_SYNC_HI   = 4'd3,
    PH_SYNC_LO   = 4'd4,
    PH_BIT_HI    = 4'd5,
    PH_BIT_LO    = 4'd6,
    PH_SETTLE    = 4'd7,
    PH_BUSY_POST = 4'd8
  } phase_t;

  typedef struct packed {
    logic [TICK_W-1:0] sync_high_ticks;
    logic [TICK_W-1:0] sync_low_ticks;
    logic [TICK_W-1:0] long_ticks;
    logic [TICK_W-1:0] short_ticks;
    logic [TICK_W-1:0] power_up_ticks;
    logic [TICK_W-1:0] settle_ticks;
    logic [7:0]        volume_byte;
  } cfg_t;

  typedef struct packed {
    logic        command;
    logic [31:0] voice_word;
    logic        busy_pin;
  } in_beat_t;

  typedef struct packed {
    logic data_pin;
    logic power_enable;
    logic active;
    logic finished;
  } out_beat_t;

endpackage

// ===== rtl/one_wire_voice_command_sender_top.sv =====
// The block takes one beat per clock unless in_stall holds it: a time tick or a start
// request. Each accepted beat is held in an input register; once the output is not
// stalled, the sequencer advances one step and its result is loaded into the output
// register, and a new beat is taken every cycle while results are drained. A start
// latches the voice word and switches power on; the frames follow as ticks arrive.
// Top level of the one-wire voice command sender.
// Depends on owvcs_pkg, owvcs_cfg and owvcs_seq.
module one_wire_voice_command_sender_top #(
  parameter int TIMER_WIDTH = owvcs_pkg::TIMER_WIDTH_DEF,
  parameter int WORD_BYTES  = owvcs_pkg::WORD_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  owvcs_pkg::in_beat_t               in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output owvcs_pkg::out_beat_t              out_data,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [owvcs_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [owvcs_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [owvcs_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                              cfg_pready
);

  owvcs_pkg::cfg_t      cfg;
  owvcs_pkg::in_beat_t  stage_r;
  logic                 stage_v_r;
  owvcs_pkg::out_beat_t result;
  owvcs_pkg::out_beat_t out_r;
  logic                 out_v_r;
  logic                 advance;

  assign advance   = stage_v_r && !(out_v_r && out_stall);
  assign in_stall  = stage_v_r && out_v_r && out_stall;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  owvcs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  owvcs_seq #(
    .TIMER_WIDTH (TIMER_WIDTH),
    .WORD_BYTES  (WORD_BYTES)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .beat   (stage_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      if (!in_stall) begin
        stage_v_r <= in_valid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      stage_r <= in_data;
    end
    if (advance) begin
      out_r <= result;
    end
  end

`ifndef SYNTHESIS
  a_fin_power_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.finished |-> !out_data.power_enable && !out_data.active)
    else $error("finished beat with power still on");

  a_active_power: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.active == out_data.power_enable)
    else $error("active and power enable disagree");

  a_pin_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.data_pin |-> out_data.active)
    else $error("data line driven high while idle");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");
`endif

endmodule

// ===== rtl/owvcs_cfg.sv =====
// Configuration register file with an APB-style access port.
// Depends on owvcs_pkg for the register map and reset values.
module owvcs_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [owvcs_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [owvcs_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [owvcs_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready,
  output owvcs_pkg::cfg_t                     cfg
);

  owvcs_pkg::cfg_t       cfg_r;
  owvcs_pkg::cfg_t       cfg_nxt;
  owvcs_pkg::reg_idx_t   idx;
  logic                  wr_en;

  assign idx    = owvcs_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        owvcs_pkg::REG_SYNC_HIGH: cfg_nxt.sync_high_ticks = pwdata[15:0];
        owvcs_pkg::REG_SYNC_LOW:  cfg_nxt.sync_low_ticks  = pwdata[15:0];
        owvcs_pkg::REG_LONG:      cfg_nxt.long_ticks      = pwdata[15:0];
        owvcs_pkg::REG_SHORT:     cfg_nxt.short_ticks     = pwdata[15:0];
        owvcs_pkg::REG_POWER_UP:  cfg_nxt.power_up_ticks  = pwdata[15:0];
        owvcs_pkg::REG_SETTLE:    cfg_nxt.settle_ticks    = pwdata[15:0];
        owvcs_pkg::REG_VOLUME:    cfg_nxt.volume_byte     = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      owvcs_pkg::REG_SYNC_HIGH: prdata = {16'b0, cfg_r.sync_high_ticks};
      owvcs_pkg::REG_SYNC_LOW:  prdata = {16'b0, cfg_r.sync_low_ticks};
      owvcs_pkg::REG_LONG:      prdata = {16'b0, cfg_r.long_ticks};
      owvcs_pkg::REG_SHORT:     prdata = {16'b0, cfg_r.short_ticks};
      owvcs_pkg::REG_POWER_UP:  prdata = {16'b0, cfg_r.power_up_ticks};
      owvcs_pkg::REG_SETTLE:    prdata = {16'b0, cfg_r.settle_ticks};
      owvcs_pkg::REG_VOLUME:    prdata = {24'b0, cfg_r.volume_byte};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_high_ticks <= owvcs_pkg::SYNC_HIGH_RST;
      cfg_r.sync_low_ticks  <= owvcs_pkg::SYNC_LOW_RST;
      cfg_r.long_ticks      <= owvcs_pkg::LONG_RST;
      cfg_r.short_ticks     <= owvcs_pkg::SHORT_RST;
      cfg_r.power_up_ticks  <= owvcs_pkg::POWER_UP_RST;
      cfg_r.settle_ticks    <= owvcs_pkg::SETTLE_RST;
      cfg_r.volume_byte     <= owvcs_pkg::VOLUME_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/owvcs_seq.sv =====
// Frame sequencer: state registers and the one-step update for one beat.
// Depends on owvcs_pkg for phases, beat types and the configuration struct.
module owvcs_seq #(
  parameter int TIMER_WIDTH = owvcs_pkg::TIMER_WIDTH_DEF,
  parameter int WORD_BYTES  = owvcs_pkg::WORD_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  owvcs_pkg::in_beat_t  beat,
  input  owvcs_pkg::cfg_t      cfg,
  output owvcs_pkg::out_beat_t result
);

  localparam int PW = 8 * WORD_BYTES;
  localparam int BW = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;
  localparam int CW = $clog2(WORD_BYTES + 1);
  localparam logic [32:0] TMAX = (33'd1 << TIMER_WIDTH) - 33'd1;
  localparam logic [CW-1:0] ALL_BYTES = CW'(WORD_BYTES);

  owvcs_pkg::phase_t      phase_r, phase_nxt;
  logic [TIMER_WIDTH-1:0] cd_r, cd_nxt;
  logic [2:0]             bit_r, bit_nxt;
  logic [BW-1:0]          slot_r, slot_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic [PW-1:0]          pend_r, pend_nxt;
  logic                   line_r, line_nxt;
  logic                   power_r, power_nxt;
  logic                   vol_r, vol_nxt;
  logic                   fin;

  logic [CW-1:0]          below;
  logic [BW-1:0]          sel_slot;
  logic [7:0]             sel_byte;
  logic [7:0]             shifted;

  function automatic logic [TIMER_WIDTH-1:0] clamp(input logic [15:0] v);
    logic [32:0] ext;
    ext = {17'b0, v};
    if (v == 16'd0) begin
      clamp = TIMER_WIDTH'(1);
    end else if (ext > TMAX) begin
      clamp = TMAX[TIMER_WIDTH-1:0];
    end else begin
      clamp = ext[TIMER_WIDTH-1:0];
    end
  endfunction

  assign below    = (phase_r == owvcs_pkg::PH_BUSY_POST) ? CW'(slot_r) : ALL_BYTES;
  assign shifted  = {shift_r[6:0], 1'b0};
  assign sel_byte = pend_r[8*sel_slot +: 8];

  always_comb begin
    sel_slot = '0;
    for (int k = 1; k < WORD_BYTES; k++) begin
      if ((k < int'(below)) && (pend_r[8*k +: 8] != 8'h00)) begin
        sel_slot = BW'(k);
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    cd_nxt    = cd_r;
    bit_nxt   = bit_r;
    slot_nxt  = slot_r;
    shift_nxt = shift_r;
    pend_nxt  = pend_r;
    line_nxt  = line_r;
    power_nxt = power_r;
    vol_nxt   = vol_r;
    fin       = 1'b0;
    if (beat.command) begin
      if (phase_r == owvcs_pkg::PH_IDLE) begin
        pend_nxt  = PW'(beat.voice_word);
        power_nxt = 1'b1;
        line_nxt  = 1'b0;
        slot_nxt  = '0;
        bit_nxt   = '0;
        vol_nxt   = 1'b0;
        phase_nxt = owvcs_pkg::PH_POWERUP;
        cd_nxt    = clamp(cfg.power_up_ticks);
      end
    end else begin
      unique case (phase_r)
        owvcs_pkg::PH_IDLE: ;
        owvcs_pkg::PH_BUSY_PRE: begin
          if (!beat.busy_pin) begin
            vol_nxt   = 1'b1;
            shift_nxt = cfg.volume_byte;
            bit_nxt   = '0;
            line_nxt  = 1'b1;
            phase_nxt = owvcs_pkg::PH_SYNC_HI;
            cd_nxt    = clamp(cfg.sync_high_ticks);
          end
        end
        owvcs_pkg::PH_BUSY_POST: begin
          if (!beat.busy_pin) begin
            if (slot_r == '0) begin
              power_nxt = 1'b0;
              line_nxt  = 1'b0;
              phase_nxt = owvcs_pkg::PH_IDLE;
              cd_nxt    = '0;
              fin       = 1'b1;
            end else begin
              slot_nxt  = sel_slot;
              vol_nxt   = 1'b0;
              shift_nxt = sel_byte;
              bit_nxt   = '0;
              line_nxt  = 1'b1;
              phase_nxt = owvcs_pkg::PH_SYNC_HI;
              cd_nxt    = clamp(cfg.sync_high_ticks);
            end
          end
        end
        default: begin
          if (cd_r > TIMER_WIDTH'(1)) begin
            cd_nxt = cd_r - TIMER_WIDTH'(1);
          end else begin
            unique case (phase_r)
              owvcs_pkg::PH_POWERUP: begin
                phase_nxt = owvcs_pkg::PH_BUSY_PRE;
                cd_nxt    = '0;
              end
              owvcs_pkg::PH_SYNC_HI: begin
                line_nxt  = 1'b0;
                phase_nxt = owvcs_pkg::PH_SYNC_LO;
                cd_nxt    = clamp(cfg.sync_low_ticks);
              end
              owvcs_pkg::PH_SYNC_LO: begin
                line_nxt  = 1'b1;
                phase_nxt = owvcs_pkg::PH_BIT_HI;
                cd_nxt    = clamp(shift_r[7] ? cfg.long_ticks : cfg.short_ticks);
              end
              owvcs_pkg::PH_BIT_HI: begin
                line_nxt  = 1'b0;
                phase_nxt = owvcs_pkg::PH_BIT_LO;
                cd_nxt    = clamp(shift_r[7] ? cfg.short_ticks : cfg.long_ticks);
              end
              owvcs_pkg::PH_BIT_LO: begin
                shift_nxt = shifted;
                if (bit_r == 3'd7) begin
                  bit_nxt = '0;
                  if (vol_r) begin
                    slot_nxt  = sel_slot;
                    vol_nxt   = 1'b0;
                    shift_nxt = sel_byte;
                    line_nxt  = 1'b1;
                    phase_nxt = owvcs_pkg::PH_SYNC_HI;
                    cd_nxt    = clamp(cfg.sync_high_ticks);
                  end else begin
                    phase_nxt = owvcs_pkg::PH_SETTLE;
                    cd_nxt    = clamp(cfg.settle_ticks);
                  end
                end else begin
                  bit_nxt   = bit_r + 3'd1;
                  line_nxt  = 1'b1;
                  phase_nxt = owvcs_pkg::PH_BIT_HI;
                  cd_nxt    = clamp(shifted[7] ? cfg.long_ticks : cfg.short_ticks);
                end
              end
              owvcs_pkg::PH_SETTLE: begin
                phase_nxt = owvcs_pkg::PH_BUSY_POST;
                cd_nxt    = '0;
              end
              default: phase_nxt = owvcs_pkg::PH_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  assign result.data_pin     = line_nxt;
  assign result.power_enable = power_nxt;
  assign result.active       = (phase_nxt != owvcs_pkg::PH_IDLE);
  assign result.finished     = fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= owvcs_pkg::PH_IDLE;
      cd_r    <= '0;
      bit_r   <= '0;
      slot_r  <= '0;
      shift_r <= '0;
      pend_r  <= '0;
      line_r  <= 1'b0;
      power_r <= 1'b0;
      vol_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cd_r    <= cd_nxt;
      bit_r   <= bit_nxt;
      slot_r  <= slot_nxt;
      shift_r <= shift_nxt;
      pend_r  <= pend_nxt;
      line_r  <= line_nxt;
      power_r <= power_nxt;
      vol_r   <= vol_nxt;
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for one_wire_voice_command_sender_top, driving random beats and APB writes.
// A tracker class predicts every output beat and compares it with what the block returns.
// Depends on owvcs_pkg and one_wire_voice_command_sender_top.
module tb;

  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASE_BEATS = 40;
  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  typedef enum {SET_ZERO, SET_TINY, SET_MIXED, SET_LONG_WAITS} setting_t;

  class voice_line_tracker;
    owvcs_pkg::cfg_t        cfg;
    owvcs_pkg::phase_t      ph;
    logic [15:0]            cnt;
    logic [2:0]             nbits;
    logic [2:0]             slot;
    logic [7:0]             shreg;
    logic [31:0]            word;
    logic                   lvl;
    logic                   pwr;
    logic                   vol_frame;
    owvcs_pkg::out_beat_t   expected_levels[$];
    int                     errors;

    function new();
      cfg.sync_high_ticks = owvcs_pkg::SYNC_HIGH_RST;
      cfg.sync_low_ticks  = owvcs_pkg::SYNC_LOW_RST;
      cfg.long_ticks      = owvcs_pkg::LONG_RST;
      cfg.short_ticks     = owvcs_pkg::SHORT_RST;
      cfg.power_up_ticks  = owvcs_pkg::POWER_UP_RST;
      cfg.settle_ticks    = owvcs_pkg::SETTLE_RST;
      cfg.volume_byte     = owvcs_pkg::VOLUME_RST;
      ph = owvcs_pkg::PH_IDLE;
      cnt = '0;
      nbits = '0;
      slot = '0;
      shreg = '0;
      word = '0;
      lvl = 1'b0;
      pwr = 1'b0;
      vol_frame = 1'b0;
      errors = 0;
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 100) $display("%0t mismatch: %s", $time, what);
    endtask

    function logic [15:0] fit(logic [15:0] v);
      return (v == 16'd0) ? 16'd1 : v;
    endfunction

    function logic [7:0] byte_of(int k);
      return word[8*k +: 8];
    endfunction

    function void begin_frame(logic [7:0] b);
      shreg = b;
      nbits = '0;
      lvl = 1'b1;
      ph = owvcs_pkg::PH_SYNC_HI;
      cnt = fit(cfg.sync_high_ticks);
    endfunction

    function void load_bit();
      lvl = 1'b1;
      ph = owvcs_pkg::PH_BIT_HI;
      cnt = fit(shreg[7] ? cfg.long_ticks : cfg.short_ticks);
    endfunction

    function void next_word_byte(int below);
      int k;
      logic found;
      found = 1'b0;
      slot = 3'd0;
      for (k = below - 1; k >= 1; k--) begin
        if (!found && byte_of(k) != 8'd0) begin
          found = 1'b1;
          slot = 3'(k);
        end
      end
      vol_frame = 1'b0;
      begin_frame(byte_of(slot));
    endfunction

    function bit active();
      return ph != owvcs_pkg::PH_IDLE;
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        owvcs_pkg::REG_SYNC_HIGH: cfg.sync_high_ticks = v[15:0];
        owvcs_pkg::REG_SYNC_LOW:  cfg.sync_low_ticks  = v[15:0];
        owvcs_pkg::REG_LONG:      cfg.long_ticks      = v[15:0];
        owvcs_pkg::REG_SHORT:     cfg.short_ticks     = v[15:0];
        owvcs_pkg::REG_POWER_UP:  cfg.power_up_ticks  = v[15:0];
        owvcs_pkg::REG_SETTLE:    cfg.settle_ticks    = v[15:0];
        owvcs_pkg::REG_VOLUME:    cfg.volume_byte     = v[7:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [2:0] idx);
      case (idx)
        owvcs_pkg::REG_SYNC_HIGH: return {16'd0, cfg.sync_high_ticks};
        owvcs_pkg::REG_SYNC_LOW:  return {16'd0, cfg.sync_low_ticks};
        owvcs_pkg::REG_LONG:      return {16'd0, cfg.long_ticks};
        owvcs_pkg::REG_SHORT:     return {16'd0, cfg.short_ticks};
        owvcs_pkg::REG_POWER_UP:  return {16'd0, cfg.power_up_ticks};
        owvcs_pkg::REG_SETTLE:    return {16'd0, cfg.settle_ticks};
        owvcs_pkg::REG_VOLUME:    return {24'd0, cfg.volume_byte};
        default:                  return 32'd0;
      endcase
    endfunction

    function void take_beat(owvcs_pkg::in_beat_t b);
      owvcs_pkg::out_beat_t e;
      logic fin;
      fin = 1'b0;
      if (b.command) begin
        if (ph == owvcs_pkg::PH_IDLE) begin
          word = b.voice_word;
          pwr = 1'b1;
          lvl = 1'b0;
          slot = '0;
          nbits = '0;
          vol_frame = 1'b0;
          ph = owvcs_pkg::PH_POWERUP;
          cnt = fit(cfg.power_up_ticks);
        end
      end else if (ph == owvcs_pkg::PH_BUSY_PRE) begin
        if (!b.busy_pin) begin
          vol_frame = 1'b1;
          begin_frame(cfg.volume_byte);
        end
      end else if (ph == owvcs_pkg::PH_BUSY_POST) begin
        if (!b.busy_pin) begin
          if (slot == 3'd0) begin
            pwr = 1'b0;
            lvl = 1'b0;
            ph = owvcs_pkg::PH_IDLE;
            cnt = '0;
            fin = 1'b1;
          end else begin
            next_word_byte(slot);
          end
        end
      end else if (ph != owvcs_pkg::PH_IDLE) begin
        if (cnt > 16'd1) begin
          cnt = cnt - 16'd1;
        end else begin
          case (ph)
            owvcs_pkg::PH_POWERUP: begin
              ph = owvcs_pkg::PH_BUSY_PRE;
              cnt = '0;
            end
            owvcs_pkg::PH_SYNC_HI: begin
              lvl = 1'b0;
              ph = owvcs_pkg::PH_SYNC_LO;
              cnt = fit(cfg.sync_low_ticks);
            end
            owvcs_pkg::PH_SYNC_LO: load_bit();
            owvcs_pkg::PH_BIT_HI: begin
              lvl = 1'b0;
              ph = owvcs_pkg::PH_BIT_LO;
              cnt = fit(shreg[7] ? cfg.short_ticks : cfg.long_ticks);
            end
            owvcs_pkg::PH_BIT_LO: begin
              shreg = {shreg[6:0], 1'b0};
              if (nbits == 3'd7) begin
                nbits = '0;
                if (vol_frame) begin
                  next_word_byte(owvcs_pkg::WORD_BYTES_DEF);
                end else begin
                  ph = owvcs_pkg::PH_SETTLE;
                  cnt = fit(cfg.settle_ticks);
                end
              end else begin
                nbits = nbits + 3'd1;
                load_bit();
              end
            end
            owvcs_pkg::PH_SETTLE: begin
              ph = owvcs_pkg::PH_BUSY_POST;
              cnt = '0;
            end
            default: ph = owvcs_pkg::PH_IDLE;
          endcase
        end
      end
      e.data_pin = lvl;
      e.power_enable = pwr;
      e.active = (ph != owvcs_pkg::PH_IDLE);
      e.finished = fin;
      expected_levels.push_back(e);
    endfunction

    task compare_levels(owvcs_pkg::out_beat_t got);
      owvcs_pkg::out_beat_t e;
      if (expected_levels.size() == 0) begin
        report_mismatch("output beat arrived with nothing expected");
      end else begin
        e = expected_levels.pop_front();
        if (got.data_pin !== e.data_pin)
          report_mismatch($sformatf("data_pin got %b want %b", got.data_pin, e.data_pin));
        if (got.power_enable !== e.power_enable)
          report_mismatch($sformatf("power_enable got %b want %b",
                                    got.power_enable, e.power_enable));
        if (got.active !== e.active)
          report_mismatch($sformatf("active got %b want %b", got.active, e.active));
        if (got.finished !== e.finished)
          report_mismatch($sformatf("finished got %b want %b", got.finished, e.finished));
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  owvcs_pkg::in_beat_t  in_data;
  logic                 out_valid;
  logic                 out_stall;
  owvcs_pkg::out_beat_t out_data;
  logic                 cfg_psel;
  logic                 cfg_penable;
  logic                 cfg_pwrite;
  logic [owvcs_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [owvcs_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [owvcs_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                 cfg_pready;

  voice_line_tracker tracker;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int quiet = 0;

  one_wire_voice_command_sender_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) tracker.take_beat(in_data);
      if (out_valid && !out_stall) tracker.compare_levels(out_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_psel) begin
      quiet <= 0;
    end else if (quiet >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // The receiver alternates between free flow, random stalls and a heavy periodic stall.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(5, 60);
    end
    stall_left = stall_left - 1;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= (stall_left % 4 != 0);
    endcase
  end

  task automatic send_beat(input owvcs_pkg::in_beat_t b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= b;
    burst_left--;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] v);
    logic [31:0] rd;
    cfg_access(1'b1, idx, v, rd);
    tracker.write_reg(idx, v);
  endtask

  task automatic cfg_check(input logic [2:0] idx);
    logic [31:0] rd;
    cfg_access(1'b0, idx, 32'd0, rd);
    if (rd !== tracker.reg_value(idx))
      tracker.report_mismatch($sformatf("register %0d read %h want %h",
                                        idx, rd, tracker.reg_value(idx)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    int i;
    case ($urandom_range(0, 7))
      0: w = 32'd0;
      1: w = 32'hFFFF_FFFF;
      default: begin
        for (i = 0; i < 4; i++)
          w[8*i +: 8] = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(1, 255)) : 8'h00;
      end
    endcase
    return w;
  endfunction

  function automatic owvcs_pkg::in_beat_t make_beat();
    owvcs_pkg::in_beat_t b;
    b.voice_word = $urandom;
    b.busy_pin = ($urandom_range(0, 2) == 0);
    if (tracker.active()) b.command = ($urandom_range(0, 15) == 0);
    else b.command = ($urandom_range(0, 2) == 0);
    if (b.command && !tracker.active()) b.voice_word = pick_word();
    return b;
  endfunction

  task automatic load_setting(input setting_t s);
    logic [31:0] v;
    int i;
    for (i = owvcs_pkg::REG_SYNC_HIGH; i <= owvcs_pkg::REG_VOLUME; i++) begin
      v = $urandom;
      case (s)
        SET_ZERO:
          v = (i == owvcs_pkg::REG_VOLUME) ? {v[31:8], 8'h00} : {v[31:16], 16'h0000};
        SET_TINY:
          v = (i == owvcs_pkg::REG_VOLUME) ? 32'h0000_00FF : 32'($urandom_range(1, 2));
        SET_MIXED:
          v = (i == owvcs_pkg::REG_VOLUME) ? v : {v[31:16], 16'($urandom_range(0, 2))};
        default: begin
          if (i == owvcs_pkg::REG_POWER_UP || i == owvcs_pkg::REG_SETTLE)
            v = {16'hFFFF, 16'd24};
          else if (i != owvcs_pkg::REG_VOLUME) v = 32'($urandom_range(0, 1));
        end
      endcase
      cfg_write(3'(i), v);
      cfg_check(3'(i));
    end
    cfg_write(REG_UNMAPPED, $urandom);
    for (i = owvcs_pkg::REG_SYNC_HIGH; i <= owvcs_pkg::REG_VOLUME; i++) cfg_check(3'(i));
  endtask

  task automatic run_phase(input int beats, input bit to_idle);
    int n;
    for (n = 0; n < beats; n++) send_beat(make_beat());
    if (to_idle) begin
      while (tracker.active()) send_beat(make_beat());
    end
  endtask

  initial begin
    int i;
    owvcs_pkg::in_beat_t b;
    tracker = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = owvcs_pkg::REG_SYNC_HIGH; i <= owvcs_pkg::REG_VOLUME; i++) cfg_check(3'(i));
    load_setting(SET_TINY);

    // Idle ticks, a start with every byte set, an ignored start, then busy held on.
    send_beat('{command: 1'b0, voice_word: 32'd0, busy_pin: 1'b0});
    send_beat('{command: 1'b0, voice_word: 32'hFFFF_FFFF, busy_pin: 1'b1});
    send_beat('{command: 1'b1, voice_word: 32'hFFFF_FFFF, busy_pin: 1'b1});
    send_beat('{command: 1'b1, voice_word: 32'd0, busy_pin: 1'b0});
    for (i = 0; i < 14; i++) begin
      b.command = 1'b0;
      b.voice_word = $urandom;
      b.busy_pin = (i < 8);
      send_beat(b);
    end
    run_phase(PHASE_BEATS, 1'b1);

    drain();
    load_setting(SET_ZERO);
    run_phase(PHASE_BEATS, 1'b1);

    // This phase may stop in the middle of a sequence, so the next setting lands mid-flight.
    drain();
    load_setting(SET_MIXED);
    run_phase(PHASE_BEATS, 1'b0);

    drain();
    load_setting(SET_TINY);
    run_phase(PHASE_BEATS, 1'b1);

    drain();
    load_setting(SET_LONG_WAITS);
    send_beat('{command: 1'b1, voice_word: {24'd0, 8'($urandom)}, busy_pin: 1'b0});
    while (tracker.active()) send_beat(make_beat());

    drain();
    load_setting(SET_MIXED);
    run_phase(PHASE_BEATS, 1'b1);

    drain();
    repeat (8) @(negedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== one_wire_voice_command_sender_top.f =====
rtl/owvcs_pkg.sv
rtl/owvcs_cfg.sv
rtl/owvcs_seq.sv
rtl/one_wire_voice_command_sender_top.sv
bench/tb.sv
